// ===== hdl/skvt_pkg.sv =====
`default_nettype none
package skvt_pkg;

    typedef enum logic [1:0] {
        KIND_PUT    = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_GET    = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_HIT       = 3'd2,
        ST_MISS      = 3'd3,
        ST_TOMBSTONE = 3'd4,
        ST_BAD_INDEX = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [3:0]  key_len;
        logic [63:0] value;
        logic [3:0]  val_len;
        logic [5:0]  index;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_key;
        logic [3:0]  out_key_len;
        logic [63:0] out_val;
        logic [3:0]  out_val_len;
        logic        out_tombstone;
        logic [6:0]  entry_count;
    } rsp_t;

    // one table entry as held in memory
    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  key_len;
        logic [63:0] value;
        logic [3:0]  val_len;
        logic        tombstone;
    } entry_t;

    // byte-wise then length compare over a 64-bit window, first byte highest
    // returns 2'b00 equal, 2'b01 a<b, 2'b10 a>b
    function automatic logic [1:0] key_order(
        input logic [63:0] a, input logic [3:0] alen,
        input logic [63:0] b, input logic [3:0] blen);
        logic [3:0]  m;
        logic [63:0] mk;
        logic [1:0]  r;
        begin
            m = (alen < blen) ? alen : blen;
            for (int i = 0; i < 8; i++)
            begin
                mk[63 - 8*i -: 8] = (4'(i) < m) ? 8'hff : 8'h00;
            end
            if ((a & mk) < (b & mk))
                r = 2'b01;
            else if ((a & mk) > (b & mk))
                r = 2'b10;
            else if (alen < blen)
                r = 2'b01;
            else if (alen > blen)
                r = 2'b10;
            else
                r = 2'b00;
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sorted_key_value_table.sv =====
// sorted key/value table
// command channel: an item (cmd) is taken at a clock edge with start high and
// busy low; busy is set at that edge and stays high until the result shows.
// result channel: done pulses for one cycle with rsp; the receiver cannot
// stall it, so the result must be captured in that cycle.
// a new item can be taken in the same cycle that a result is shown.
// the table lives in one synchronous memory (one write and one read port,
// read data registered); operations reach it only through these ports.
// get/put/delete: binary search, each probe a PROBE state then a CMP state,
// at most ceil(log2(CAPACITY+1)) probes.
// put/delete of a new key: the entries above the insert point move up one
// place, each entry moved read in SHRD and written one place higher in SHWR.
// read at index: RDAT reads the entry, then FINAL shows it; a bad index
// goes straight from acceptance to FINAL.
// reset clears the entry count, busy, done and the sequencer; memory contents are not
// cleared, only entries below the count are ever used.
// an insert into a full table is refused with the full status.
`default_nettype none
module sorted_key_value_table #(
    parameter int CAPACITY = 64,
    parameter int KEY_BYTES = 8,
    parameter int VALUE_BYTES = 8
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire  skvt_pkg::cmd_t cmd,
    output logic               busy,
    output logic               done,
    output skvt_pkg::rsp_t     rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_FINAL,
        S_RDAT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] lo_reg, hi_reg, mid_reg, sh_reg;
    logic [1:0]  kind_reg;
    logic [63:0] key_reg, val_reg;
    logic [3:0]  klen_reg, vlen_reg;
    logic        hit_reg;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    skvt_pkg::entry_t wdata, rdata;
    skvt_pkg::rsp_t   rsp_next;
    logic [CW-1:0]    sh_dec;
    logic             idx_ok;

    skvt_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // input masking: lengths saturate, bytes past the length read as zero
    logic [3:0]  klen_sat, vlen_sat;
    logic [63:0] key_m, val_m;
    always_comb
    begin
        klen_sat = (cmd.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : cmd.key_len;
        vlen_sat = (cmd.val_len > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES)
                                                   : cmd.val_len;
        for (int i = 0; i < 8; i++)
        begin
            key_m[63 - 8*i -: 8] = (4'(i) < klen_sat && i < KEY_BYTES)
                                   ? cmd.key[8*KEY_BYTES - 1 - 8*i -: 8] : 8'h00;
            val_m[63 - 8*i -: 8] = (4'(i) < vlen_sat && i < VALUE_BYTES)
                                   ? cmd.value[8*VALUE_BYTES - 1 - 8*i -: 8] : 8'h00;
        end
    end

    // read index check against the live count
    assign idx_ok = 32'(cmd.index) < 32'(count_reg);

    // keys are held left-aligned in a 64-bit window; convert back on output
    function automatic logic [63:0] to_port(input logic [63:0] w, input int nb);
        logic [63:0] r;
        begin
            r = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (i < nb)
                    r[8*nb - 1 - 8*i -: 8] = w[63 - 8*i -: 8];
            end
            return r;
        end
    endfunction

    logic [1:0] cmp;
    assign cmp = skvt_pkg::key_order(rdata.key, rdata.key_len, key_reg, klen_reg);

    logic [CW-1:0] mid_c;
    assign mid_c = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign sh_dec = sh_reg - 1'b1;

    // memory port control
    always_comb
    begin
        we = 1'b0;
        waddr = mid_reg[AW-1:0];
        wdata = rdata;
        raddr = mid_reg[AW-1:0];
        case (state_reg)
            S_PROBE:
                raddr = mid_c[AW-1:0];
            S_SHRD:
                raddr = sh_dec[AW-1:0];
            S_SHWR:
            begin
                we = 1'b1;
                waddr = sh_reg[AW-1:0];
                wdata = rdata;
            end
            S_FINAL:
            begin
                if (kind_reg == skvt_pkg::KIND_PUT || kind_reg == skvt_pkg::KIND_DELETE)
                begin
                    if (hit_reg || count_reg < CW'(CAPACITY))
                    begin
                        we = 1'b1;
                        waddr = hit_reg ? mid_reg[AW-1:0] : lo_reg[AW-1:0];
                        wdata.key = key_reg;
                        wdata.key_len = klen_reg;
                        wdata.value = (kind_reg == skvt_pkg::KIND_DELETE) ? '0 : val_reg;
                        wdata.val_len = (kind_reg == skvt_pkg::KIND_DELETE) ? '0 : vlen_reg;
                        wdata.tombstone = (kind_reg == skvt_pkg::KIND_DELETE);
                    end
                end
            end
            default:
                ;
        endcase
    end

    // result of the item being finished
    always_comb
    begin
        rsp_next = '0;
        rsp_next.entry_count = 7'(count_reg);
        case (kind_reg)
            skvt_pkg::KIND_PUT, skvt_pkg::KIND_DELETE:
            begin
                if (!hit_reg && count_reg >= CW'(CAPACITY))
                    rsp_next.status = skvt_pkg::ST_FULL;
                else
                begin
                    rsp_next.status = skvt_pkg::ST_DONE;
                    if (!hit_reg)
                        rsp_next.entry_count = 7'(count_reg + 1'b1);
                end
            end
            skvt_pkg::KIND_GET:
            begin
                if (!hit_reg)
                    rsp_next.status = skvt_pkg::ST_MISS;
                else if (rdata.tombstone)
                begin
                    rsp_next.status = skvt_pkg::ST_TOMBSTONE;
                    rsp_next.out_tombstone = 1'b1;
                end
                else
                begin
                    rsp_next.status = skvt_pkg::ST_HIT;
                    rsp_next.out_val = to_port(rdata.value, VALUE_BYTES);
                    rsp_next.out_val_len = rdata.val_len;
                end
            end
            default:
            begin
                // read at index: hit_reg marks an index below the count
                if (!hit_reg)
                    rsp_next.status = skvt_pkg::ST_BAD_INDEX;
                else
                begin
                    rsp_next.status = skvt_pkg::ST_DONE;
                    rsp_next.out_key = to_port(rdata.key, KEY_BYTES);
                    rsp_next.out_key_len = rdata.key_len;
                    rsp_next.out_tombstone = rdata.tombstone;
                    if (!rdata.tombstone)
                    begin
                        rsp_next.out_val = to_port(rdata.value, VALUE_BYTES);
                        rsp_next.out_val_len = rdata.val_len;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            busy <= 1'b0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && !busy)
                    begin
                        busy <= 1'b1;
                        kind_reg <= cmd.kind;
                        key_reg <= key_m;
                        klen_reg <= klen_sat;
                        val_reg <= val_m;
                        vlen_reg <= vlen_sat;
                        lo_reg <= '0;
                        hi_reg <= count_reg;
                        hit_reg <= (cmd.kind == skvt_pkg::KIND_READ) ? idx_ok : 1'b0;
                        mid_reg <= CW'(cmd.index);
                        if (cmd.kind == skvt_pkg::KIND_READ)
                            state_reg <= idx_ok ? S_RDAT : S_FINAL;
                        else
                            state_reg <= S_PROBE;
                    end
                end
                S_RDAT:
                    state_reg <= S_FINAL;
                S_PROBE:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg <= mid_c;
                        state_reg <= S_CMP;
                    end
                    else if ((kind_reg == skvt_pkg::KIND_PUT
                              || kind_reg == skvt_pkg::KIND_DELETE)
                             && count_reg < CW'(CAPACITY))
                    begin
                        sh_reg <= count_reg;
                        state_reg <= (count_reg > lo_reg) ? S_SHRD : S_FINAL;
                    end
                    else
                        state_reg <= S_FINAL;
                end
                S_CMP:
                begin
                    if (cmp == 2'b00)
                    begin
                        hit_reg <= 1'b1;
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        if (cmp == 2'b01)
                            lo_reg <= mid_reg + 1'b1;
                        else
                            hi_reg <= mid_reg;
                        state_reg <= S_PROBE;
                    end
                end
                S_SHRD:
                    state_reg <= S_SHWR;
                S_SHWR:
                begin
                    sh_reg <= sh_dec;
                    state_reg <= (sh_dec > lo_reg) ? S_SHRD : S_FINAL;
                end
                S_FINAL:
                begin
                    busy <= 1'b0;
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                    rsp <= rsp_next;
                    if ((kind_reg == skvt_pkg::KIND_PUT || kind_reg == skvt_pkg::KIND_DELETE)
                        && !hit_reg && count_reg < CW'(CAPACITY))
                        count_reg <= count_reg + 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY)) else $error("entry count over capacity");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == S_FINAL))
        else $error("count moved outside finish");
    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> lo_reg <= hi_reg)
        else $error("search window inverted");
`endif

endmodule
`default_nettype wire

// ===== hdl/skvt_mem.sv =====
`default_nettype none
module skvt_mem #(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  wire                   clk,
    input  wire                   we,
    input  wire  [AW-1:0]         waddr,
    input  wire  skvt_pkg::entry_t wdata,
    input  wire  [AW-1:0]         raddr,
    output skvt_pkg::entry_t      rdata
);

    skvt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
